[rtl/lpht_pkg.sv]
`timescale 1ns / 1ps

package lpht_pkg;

    localparam int KEY_W     = 31;
    localparam int VALUE_W   = 32;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;

    // tdata on the request side carries key and value, padded to whole bytes
    localparam int IN_TDATA_W  = ((KEY_W + VALUE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((VALUE_W + 7) / 8) * 8;

    // home slot reduction: DIGIT_W key bits per cycle
    localparam int DIGIT_W   = 4;
    localparam int MOD_STEPS = (KEY_W + DIGIT_W - 1) / DIGIT_W;
    localparam int PAD_W     = MOD_STEPS * DIGIT_W;
    localparam int STEP_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2,
        ST_UNUSED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MARK_EMPTY   = 2'd0,
        MARK_USED    = 2'd1,
        MARK_DELETED = 2'd2,
        MARK_UNUSED  = 2'd3
    } mark_t;

    typedef struct packed {
        mark_t              mark;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } slot_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_ISSUE,
        S_PROBE,
        S_RESP
    } state_t;

endpackage

[rtl/linear_probe_hash_table_unit.sv]
`timescale 1ns / 1ps

// Linear-probing key-value table of SLOTS slots held in one slot memory.
// Requests enter on the s_* stream: opcode in s_tuser, key and value in
// s_tdata. Each request returns exactly one response on the m_* stream:
// status in m_tuser, the found value (else zero) in m_tdata.
// A request is accepted, its key is reduced to its home slot (the reducer
// is loaded, then the eight key digits are folded in), the memory read is
// started, and the walk visits 1 to SLOTS slots (one memory read per
// cycle); then the response register is loaded.
// Insert (unless full) and remove (on a hit) write the slot memory in the
// cycle the walk ends. An unused opcode skips the walk and answers "not found".
// One request is in flight at a time; the next one is taken as soon as the
// response sits in the output register, even while the receiver stalls.
// A stalled response holds m_tvalid and its data until taken; a finished
// walk then waits before loading it.
// After reset the block sweeps the memory, marking every slot empty;
// s_tready stays low during that sweep.
module linear_probe_hash_table_unit #(
    parameter int SLOTS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [lpht_pkg::IN_TDATA_W-1:0]      s_tdata,   // key, value, zero pad
    input  logic [lpht_pkg::OP_W-1:0]            s_tuser,   // opcode
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [lpht_pkg::OUT_TDATA_W-1:0]     m_tdata,   // read_value
    output logic [lpht_pkg::STATUS_W-1:0]        m_tuser    // status
);

    import lpht_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [IDX_W-1:0]   addr_reg, addr_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic               has_free_reg, has_free_next;
    logic [IDX_W-1:0]   free_reg, free_next;
    status_t            res_status_reg, res_status_next;
    logic [VALUE_W-1:0] res_value_reg, res_value_next;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;

    logic               mod_start;
    logic               mod_done;
    logic [IDX_W-1:0]   mod_home;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    slot_t              wr_word;
    logic               rd_en;
    slot_t              rd_word;

    logic               in_fire;
    logic               used;
    logic               hit;
    logic               walk_end;
    logic               free_found;
    logic [IDX_W-1:0]   free_slot;

    lpht_mod #(
        .SLOTS (SLOTS)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .key   (key_reg),
        .done  (mod_done),
        .home  (mod_home)
    );

    lpht_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_word),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_word)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = OUT_TDATA_W'(out_value_reg);

    assign used       = (rd_word.mark == MARK_USED);
    assign hit        = used && (rd_word.key == key_reg);
    assign walk_end   = (rd_word.mark == MARK_EMPTY) || (cnt_reg == LAST_SLOT);
    assign free_found = has_free_reg || !used;
    assign free_slot  = has_free_reg ? free_reg : slot_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        addr_next       = addr_reg;
        slot_next       = slot_reg;
        cnt_next        = cnt_reg;
        has_free_next   = has_free_reg;
        free_next       = free_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        mod_start       = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = addr_reg;
        wr_word.mark    = MARK_EMPTY;
        wr_word.key     = key_reg;
        wr_word.value   = value_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en     = 1'b1;
                addr_next = addr_reg + IDX_W'(1);
                if (addr_reg == LAST_SLOT)
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next    = op_t'(s_tuser);
                    key_next   = s_tdata[KEY_W-1:0];
                    value_next = s_tdata[KEY_W+VALUE_W-1:KEY_W];
                    if (op_t'(s_tuser) == OP_NONE)
                    begin
                        res_status_next = ST_MISSING;
                        res_value_next  = '0;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                if (mod_done)
                begin
                    addr_next     = mod_home;
                    cnt_next      = '0;
                    has_free_next = 1'b0;
                    state_next    = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                rd_en      = 1'b1;
                slot_next  = addr_reg;
                addr_next  = (addr_reg == LAST_SLOT) ? '0 : addr_reg + IDX_W'(1);
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (hit || walk_end)
                begin
                    res_status_next = ST_MISSING;
                    res_value_next  = '0;
                    state_next      = S_RESP;
                    wr_word.value   = rd_word.value;
                    unique case (op_reg)
                        OP_INSERT:
                        begin
                            wr_word.mark  = MARK_USED;
                            wr_word.value = value_reg;
                            if (hit)
                            begin
                                wr_en           = 1'b1;
                                wr_addr         = slot_reg;
                                res_status_next = ST_OK;
                            end
                            else if (free_found)
                            begin
                                wr_en           = 1'b1;
                                wr_addr         = free_slot;
                                res_status_next = ST_OK;
                            end
                            else
                            begin
                                res_status_next = ST_FULL;
                            end
                        end
                        OP_FIND:
                        begin
                            if (hit)
                            begin
                                res_status_next = ST_OK;
                                res_value_next  = rd_word.value;
                            end
                        end
                        OP_REMOVE:
                        begin
                            wr_word.mark = MARK_DELETED;
                            if (hit)
                            begin
                                wr_en           = 1'b1;
                                wr_addr         = slot_reg;
                                res_status_next = ST_OK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else
                begin
                    rd_en     = 1'b1;
                    slot_next = addr_reg;
                    addr_next = (addr_reg == LAST_SLOT) ? '0 : addr_reg + IDX_W'(1);
                    cnt_next  = cnt_reg + IDX_W'(1);
                    if (!has_free_reg && !used)
                    begin
                        has_free_next = 1'b1;
                        free_next     = slot_reg;
                    end
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // start the home slot reduction in the first hash cycle
        if (state_reg == S_IDLE && in_fire && op_t'(s_tuser) != OP_NONE)
        begin
            cnt_next = '0;
        end
        if (state_reg == S_HASH && !mod_done && cnt_reg == '0)
        begin
            mod_start = 1'b1;
            cnt_next  = LAST_SLOT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            cnt_reg       <= '0;
            has_free_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            cnt_reg       <= cnt_next;
            has_free_reg  <= has_free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        slot_reg       <= slot_next;
        free_reg       <= free_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end

endmodule

[rtl/lpht_ram.sv]
`timescale 1ns / 1ps

module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/lpht_mod.sv]
`timescale 1ns / 1ps

module lpht_mod #(
    parameter int SLOTS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lpht_pkg::KEY_W-1:0]    key,
    output logic                          done,
    output logic [$clog2(SLOTS)-1:0]      home
);

    import lpht_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W:0] SLOTS_C = (IDX_W + 1)'(SLOTS);

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic [PAD_W-1:0]  sh_reg;
    logic [IDX_W-1:0]  rem_reg;
    logic [IDX_W:0]    rem_next;

    // restoring remainder over one digit of the key
    always_comb
    begin
        rem_next = {1'b0, rem_reg};
        for (int i = 0; i < DIGIT_W; i++)
        begin
            rem_next = {rem_next[IDX_W-1:0], sh_reg[PAD_W-1-i]};
            if (rem_next >= SLOTS_C)
            begin
                rem_next = rem_next - SLOTS_C;
            end
        end
    end

    assign done = busy_reg && (step_reg == STEP_W'(MOD_STEPS - 1));
    assign home = rem_next[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            busy_reg <= !done;
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= PAD_W'(key);
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg  <= sh_reg << DIGIT_W;
            rem_reg <= rem_next[IDX_W-1:0];
        end
    end

endmodule
